### rtl/ist_pkg.sv
// ist_pkg: shared types and codes for the interval set table.
// No dependencies.
package ist_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_REM   = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic signed [7:0] IDX_NONE = -8'sd1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] interval_start;
        logic [31:0] interval_end;
        logic [31:0] point_time;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [7:0] found_index;
        logic [6:0]        entry_count;
    } rsp_t;

endpackage

### rtl/ist_cmp.sv
// ist_cmp: shared 33-bit compare unit used by the sequencer.
// Depends on nothing.
module ist_cmp (
    input  logic [32:0] a,
    input  logic [32:0] b,
    output logic        lt,
    output logic        eq
);
    assign lt = a < b;
    assign eq = a == b;
endmodule

### rtl/interval_set_table.sv
// interval_set_table: sorted table of disjoint inclusive intervals.
// Operation: a scan reads, then compares, each entry; a shift pass then reads and
// writes each moved entry; scan and shift together cover the table about once.
// Throughput: one request at a time; busy is high meanwhile, next request can
// be taken in the done cycle. Reset clears count and control, not the memory.
module interval_set_table #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ist_pkg::req_t  req,
    output logic           done,
    output ist_pkg::rsp_t  rsp
);
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    // state machine, one-hot
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,   // issue scan read
        S_CHK   = 9'b000000100,   // evaluate scanned entry
        S_RD2   = 9'b000001000,   // second scan (merge end)
        S_CHK2  = 9'b000010000,
        S_MVR   = 9'b000100000,   // shift: read
        S_MVW   = 9'b001000000,   // shift: write
        S_FIX   = 9'b010000000,   // final writes
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] mem [MAX_INTERVALS];
    logic [63:0] rd_data;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [63:0]   wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;     // scan index
    logic [CW-1:0] f_reg, f_next;     // first hit
    logic [CW-1:0] j_reg, j_next;     // shift cursor
    logic [CW-1:0] n_reg, n_next;     // new count
    logic [2:0]    op_reg, op_next;
    logic [31:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [63:0]   buf_reg, buf_next;
    logic [1:0]    st_reg, st_next;
    logic          up_reg, up_next;    // shift direction: 1 opens gap
    logic [1:0]    fix_reg, fix_next;  // 0 none,1 write lo,2 split
    logic signed [7:0] idx_reg, idx_next;
    logic          done_reg, done_next;

    // shared compare: operands muxed by state/op
    logic [32:0] ca, cb;
    logic        c_lt, c_eq;
    ist_cmp u_cmp (.a(ca), .b(cb), .lt(c_lt), .eq(c_eq));

    logic [31:0] es, ee;
    assign es = rd_data[63:32];
    assign ee = rd_data[31:0];

    always_comb
    begin
        ca = '0;
        cb = '0;
        unique case (op_reg)
            ist_pkg::OP_ADD, ist_pkg::OP_SET:
            begin
                if (state_reg == S_CHK)
                begin
                    ca = {1'b0, ee} + 33'd1; cb = {1'b0, lo_reg};   // end+1 < lo
                end
                else
                begin
                    ca = {1'b0, hi_reg} + 33'd1; cb = {1'b0, es};   // hi+1 < start
                end
            end
            ist_pkg::OP_REM:
            begin
                ca = {1'b0, es}; cb = {1'b0, lo_reg};
            end
            default:
            begin
                ca = {1'b0, lo_reg}; cb = {1'b0, es};   // t < start
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; i_next = i_reg; f_next = f_reg; j_next = j_reg;
        n_next = n_reg; op_next = op_reg; lo_next = lo_reg; hi_next = hi_reg;
        buf_next = buf_reg; st_next = st_reg; up_next = up_reg; fix_next = fix_reg;
        idx_next = idx_reg; done_next = 1'b0;
        raddr = i_reg[AW-1:0];
        we = 1'b0; waddr = f_reg[AW-1:0]; wdata = {lo_reg, hi_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = req.op;
                    i_next = '0;
                    st_next = ist_pkg::ST_NONE;
                    idx_next = ist_pkg::IDX_NONE;
                    fix_next = 2'd0;
                    if (req.op == ist_pkg::OP_ADD || req.op == ist_pkg::OP_REM)
                    begin
                        lo_next = req.interval_start; hi_next = req.interval_end;
                    end
                    else
                    begin
                        lo_next = req.point_time; hi_next = req.point_time;
                    end
                    if (req.op > ist_pkg::OP_QUERY ||
                        (req.op == ist_pkg::OP_ADD && req.interval_start > req.interval_end))
                        state_next = S_OUT;
                    else
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    // scan ran off the end
                    if (op_reg == ist_pkg::OP_ADD || op_reg == ist_pkg::OP_SET)
                    begin
                        f_next = i_reg;
                        state_next = S_RD2;
                    end
                    else
                        state_next = S_OUT;
                end
                else
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                unique case (op_reg)
                    ist_pkg::OP_ADD, ist_pkg::OP_SET:
                    begin
                        if (c_lt)
                        begin
                            i_next = i_reg + CW'(1); state_next = S_RD;
                        end
                        else
                        begin
                            f_next = i_reg; state_next = S_RD2;
                        end
                    end
                    ist_pkg::OP_REM:
                    begin
                        if (c_eq && ee == hi_reg)
                        begin
                            f_next = i_reg; idx_next = 8'(i_reg);
                            st_next = ist_pkg::ST_DONE;
                            n_next = cnt_reg - CW'(1);
                            up_next = 1'b0; j_next = i_reg; fix_next = 2'd0;
                            state_next = S_MVR;
                        end
                        else
                        begin
                            i_next = i_reg + CW'(1); state_next = S_RD;
                        end
                    end
                    ist_pkg::OP_QUERY:
                    begin
                        if (c_lt)
                            state_next = S_OUT;
                        else
                        begin
                            st_next = ist_pkg::ST_DONE; idx_next = 8'(i_reg);
                            i_next = i_reg + CW'(1); state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        // clear point: start <= t <= end
                        if (c_lt)
                            state_next = S_OUT;    // sorted: no later hit
                        else if (lo_reg <= ee)
                        begin
                            f_next = i_reg; idx_next = 8'(i_reg);
                            st_next = ist_pkg::ST_DONE;
                            if (es == lo_reg && ee == lo_reg)
                            begin
                                n_next = cnt_reg - CW'(1); up_next = 1'b0;
                                j_next = i_reg; fix_next = 2'd0; state_next = S_MVR;
                            end
                            else if (es == lo_reg)
                            begin
                                lo_next = lo_reg + 32'd1; hi_next = ee; state_next = S_FIX;
                                fix_next = 2'd1; n_next = cnt_reg;
                            end
                            else if (ee == lo_reg)
                            begin
                                hi_next = lo_reg - 32'd1; lo_next = es; state_next = S_FIX;
                                fix_next = 2'd1; n_next = cnt_reg;
                            end
                            else if (cnt_reg >= CW'(MAX_INTERVALS))
                            begin
                                st_next = ist_pkg::ST_FULL; idx_next = ist_pkg::IDX_NONE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                // split: open a gap at i+1
                                hi_next = lo_reg - 32'd1; lo_next = es;
                                buf_next = {lo_reg + 32'd1, ee};
                                n_next = cnt_reg + CW'(1); up_next = 1'b1;
                                j_next = cnt_reg; fix_next = 2'd2; state_next = S_MVR;
                            end
                        end
                        else
                        begin
                            i_next = i_reg + CW'(1); state_next = S_RD;
                        end
                    end
                endcase
            end
            S_RD2:
            begin
                // i scans on from f to find the last merge partner
                if (i_reg >= cnt_reg)
                    state_next = S_FIX;
                else
                    state_next = S_CHK2;
                if (i_reg >= cnt_reg)
                begin
                    if (i_reg == f_reg)
                    begin
                        if (cnt_reg >= CW'(MAX_INTERVALS))
                        begin
                            st_next = ist_pkg::ST_FULL; state_next = S_OUT;
                        end
                        else
                        begin
                            st_next = ist_pkg::ST_DONE; idx_next = 8'(f_reg);
                            n_next = cnt_reg + CW'(1); up_next = 1'b1;
                            j_next = cnt_reg; fix_next = 2'd1; state_next = S_MVR;
                        end
                    end
                    else
                    begin
                        st_next = ist_pkg::ST_DONE; idx_next = 8'(f_reg);
                        n_next = cnt_reg - (i_reg - f_reg) + CW'(1);
                        up_next = 1'b0; j_next = f_reg + CW'(1); fix_next = 2'd1;
                        state_next = S_MVR;
                    end
                end
            end
            S_CHK2:
            begin
                if (!c_lt)
                begin
                    // entry merges: widen
                    if (i_reg == f_reg && es < lo_reg) lo_next = es;
                    if (ee > hi_reg) hi_next = ee;
                    i_next = i_reg + CW'(1);
                    state_next = S_RD2;
                end
                else if (i_reg == f_reg)
                begin
                    if (cnt_reg >= CW'(MAX_INTERVALS))
                    begin
                        st_next = ist_pkg::ST_FULL; state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = ist_pkg::ST_DONE; idx_next = 8'(f_reg);
                        n_next = cnt_reg + CW'(1); up_next = 1'b1;
                        j_next = cnt_reg; fix_next = 2'd1; state_next = S_MVR;
                    end
                end
                else
                begin
                    st_next = ist_pkg::ST_DONE; idx_next = 8'(f_reg);
                    n_next = cnt_reg - (i_reg - f_reg) + CW'(1);
                    up_next = 1'b0; j_next = f_reg + CW'(1); fix_next = 2'd1;
                    state_next = S_MVR;
                end
            end
            S_MVR:
            begin
                // up: move j-1 -> j while j > f + fix gap; down: move j+(cnt-n) -> j
                if (up_reg)
                begin
                    if (j_reg > f_reg + ((fix_reg == 2'd2) ? CW'(1) : CW'(0)))
                    begin
                        raddr = AW'(j_reg - CW'(1)); state_next = S_MVW;
                    end
                    else
                        state_next = S_FIX;
                end
                else
                begin
                    if (j_reg < n_reg)
                    begin
                        raddr = AW'(j_reg + (cnt_reg - n_reg)); state_next = S_MVW;
                    end
                    else
                        state_next = (fix_reg != 2'd0) ? S_FIX : S_OUT;
                    if (!(j_reg < n_reg)) cnt_next = n_reg;
                end
            end
            S_MVW:
            begin
                we = 1'b1; waddr = j_reg[AW-1:0]; wdata = rd_data;
                j_next = up_reg ? j_reg - CW'(1) : j_reg + CW'(1);
                state_next = S_MVR;
            end
            S_FIX:
            begin
                we = (st_reg == ist_pkg::ST_DONE) || (op_reg == ist_pkg::OP_CLEAR);
                waddr = f_reg[AW-1:0]; wdata = {lo_reg, hi_reg};
                if (fix_reg == 2'd2)
                begin
                    fix_next = 2'd1;
                    we = 1'b1; waddr = AW'(f_reg + CW'(1)); wdata = buf_reg;
                end
                else
                begin
                    state_next = S_OUT;
                    if (st_reg == ist_pkg::ST_DONE) cnt_next = n_reg;
                    if (op_reg == ist_pkg::OP_CLEAR && !up_reg) cnt_next = cnt_reg;
                end
                if (op_reg == ist_pkg::OP_CLEAR && up_reg) cnt_next = n_reg;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; f_reg <= f_next; j_reg <= j_next; n_reg <= n_next;
        op_reg <= op_next; lo_reg <= lo_next; hi_reg <= hi_next;
        buf_reg <= buf_next; st_reg <= st_next; up_reg <= up_next;
        fix_reg <= fix_next; idx_reg <= idx_next;
        if (state_reg == S_OUT)
        begin
            rsp.status      <= st_reg;
            rsp.found_index <= idx_reg;
            rsp.entry_count <= 7'(cnt_reg);
        end
    end

endmodule

### rtl/ist_checker.sv
// ist_checker: port-level checks for interval_set_table, with bind.
// Depends on ist_pkg; the bind targets interval_set_table.
module ist_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ist_pkg::rsp_t rsp
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.status != 2'd3) else $error("bad status");
    a_none_idx: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ist_pkg::ST_DONE |-> rsp.found_index == ist_pkg::IDX_NONE)
        else $error("index on failure");
endmodule

bind interval_set_table ist_checker u_ist_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
